@@ rtl/assert_macros.svh @@
// Assertion macros for the spring-damper force block.
// Expects clk_i and active-low rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define SDF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset
`define SDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sdf_pkg.sv @@
// Shared widths, pipeline depths, register codes and lane result type
// for the spring-damper force block. No dependencies.
package sdf_pkg;

  localparam int NumAxes    = 3;
  localparam int CoordW     = 32;               // Q16.16 coordinate and force
  localparam int CoefW      = 32;               // unsigned Q16.16 coefficient
  localparam int DiffW      = CoordW + 1;       // posA - posB
  localparam int SqW        = 2 * DiffW - 1;    // |d|^2, at most 2^64
  localparam int SumW       = SqW + 1;          // sum of three squares
  localparam int RadW       = 2 * ((SumW + 1) / 2) + 2;
  localparam int LenW       = RadW / 2;         // floor square root
  localparam int RemW       = LenW + 2;         // square root remainder
  localparam int SqrtStages = LenW;             // one root bit per stage
  localparam int ErrW       = LenW + 1;         // signed L - r
  localparam int KdW        = CoefW + DiffW;    // k*|d|
  localparam int KdLoW      = DiffW;            // low slice of k*|d|
  localparam int PlW        = KdLoW + LenW;
  localparam int PhW        = (KdW - KdLoW) + LenW;
  localparam int SprW       = KdW + LenW;       // |k*d*e|, units 2^-48
  localparam int PdW        = CoefW + CoordW;   // c*|v|, units 2^-32
  localparam int DampShift  = 16;               // 2^-32 to 2^-48
  localparam int AccW       = SprW + 3;         // signed force, units 2^-48
  localparam int FracDrop   = 32;               // 2^-48 to Q16.16

  // Pipeline timing, counted in registers after the accepting edge
  localparam int LaneTaps   = SqrtStages + 3;   // d and v held up to the root
  localparam int LatLen     = 3 + SqrtStages;   // root registered
  localparam int LatLane    = LatLen + 5;       // lane force registered
  localparam int Latency    = LatLane + 1;      // merged result registered
  localparam int ZeroTaps   = LatLane - 3;

  localparam int CfgIdxW    = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegEnable    = 3'd0,
    RegStiffX    = 3'd1,
    RegStiffY    = 3'd2,
    RegStiffZ    = 3'd3,
    RegDampX     = 3'd4,
    RegDampY     = 3'd5,
    RegDampZ     = 3'd6,
    RegRestLen   = 3'd7
  } sdf_reg_e;

  typedef struct packed {
    logic [CoordW-1:0] force_a;
    logic [CoordW-1:0] force_b;
    logic              sat;
  } sdf_lane_res_t;

endpackage

@@ rtl/sdf_sqrt.sv @@
// Pipelined floor square root, one root bit resolved per stage.
// Depends on sdf_pkg.
module sdf_sqrt (
  input  logic                       clk_i,
  input  logic [sdf_pkg::SumW-1:0]   rad_i,
  output logic [sdf_pkg::LenW-1:0]   root_o
);
  import sdf_pkg::*;

  logic [RemW-1:0] rem_s  [SqrtStages+1];
  logic [LenW-1:0] root_s [SqrtStages+1];
  logic [RadW-1:0] rad_s  [SqrtStages+1];

  // Seed the first stage
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign rad_s[0]  = RadW'(rad_i);

  for (genvar g = 0; g < SqrtStages; g++) begin : g_stage
    logic [RemW+1:0] rem_sh;
    logic [RemW+1:0] trial;
    logic            take;
    logic [RemW-1:0] rem_q;
    logic [LenW-1:0] root_q;
    logic [RadW-1:0] rad_q;

    // Bring down the next bit pair and try the next root bit
    always_comb begin
      rem_sh = {rem_s[g], rad_s[g][RadW-1 -: 2]};
      trial  = (RemW+2)'({root_s[g], 2'b01});
      take   = rem_sh >= trial;
    end

    always_ff @(posedge clk_i) begin
      rem_q  <= take ? RemW'(rem_sh - trial) : RemW'(rem_sh);
      root_q <= {root_s[g][LenW-2:0], take};
      rad_q  <= {rad_s[g][RadW-3:0], 2'b00};
    end

    assign rem_s[g+1]  = rem_q;
    assign root_s[g+1] = root_q;
    assign rad_s[g+1]  = rad_q;
  end

  assign root_o = root_s[SqrtStages];

endmodule

@@ rtl/sdf_lane.sv @@
// One axis lane: difference and square, then spring and damping forces,
// floor to Q16.16 and clamp once the shared length arrives. Depends on sdf_pkg.
module sdf_lane (
  input  logic                              clk_i,
  input  logic signed [sdf_pkg::CoordW-1:0] pos_a_i,
  input  logic signed [sdf_pkg::CoordW-1:0] pos_b_i,
  input  logic signed [sdf_pkg::CoordW-1:0] vel_a_i,
  input  logic signed [sdf_pkg::CoordW-1:0] vel_b_i,
  input  logic        [sdf_pkg::CoefW-1:0]  stiff_i,
  input  logic        [sdf_pkg::CoefW-1:0]  damp_i,
  input  logic        [sdf_pkg::CoefW-1:0]  rest_i,
  input  logic        [sdf_pkg::LenW-1:0]   len_i,
  output logic        [sdf_pkg::SqW-1:0]    sq_o,
  output sdf_pkg::sdf_lane_res_t            res_o
);
  import sdf_pkg::*;

  typedef struct packed {
    logic [DiffW-1:0]  d;
    logic [CoordW-1:0] va;
    logic [CoordW-1:0] vb;
  } tap_t;

  typedef struct packed {
    logic [PdW-1:0] pa;
    logic [PdW-1:0] pb;
    logic           neg_s;
    logic           pos_va;
    logic           pos_vb;
  } dmp_t;

  tap_t             dl_q [LaneTaps];
  logic [DiffW-1:0] d0_abs;
  logic [SqW-1:0]   sq_q;

  // Take the difference and hold the beat until the root is ready
  always_ff @(posedge clk_i) begin
    dl_q[0] <= '{d:  {pos_a_i[CoordW-1], pos_a_i} - {pos_b_i[CoordW-1], pos_b_i},
                 va: vel_a_i, vb: vel_b_i};
    for (int j = 1; j < LaneTaps; j++) begin
      dl_q[j] <= dl_q[j-1];
    end
  end

  // Square the difference
  assign d0_abs = dl_q[0].d[DiffW-1] ? -dl_q[0].d : dl_q[0].d;

  always_ff @(posedge clk_i) begin
    sq_q <= SqW'(d0_abs) * SqW'(d0_abs);
  end

  assign sq_o = sq_q;

  // Length error and the first products
  tap_t              tl;
  logic [DiffW-1:0]  d_abs;
  logic [CoordW-1:0] va_abs;
  logic [CoordW-1:0] vb_abs;
  logic [ErrW-1:0]   e_w;
  logic [ErrW-1:0]   e_mag;

  always_comb begin
    tl     = dl_q[LaneTaps-1];
    d_abs  = tl.d[DiffW-1] ? -tl.d : tl.d;
    va_abs = tl.va[CoordW-1] ? -tl.va : tl.va;
    vb_abs = tl.vb[CoordW-1] ? -tl.vb : tl.vb;
    e_w    = ErrW'(len_i) - ErrW'(rest_i);
    e_mag  = e_w[ErrW-1] ? -e_w : e_w;
  end

  logic [KdW-1:0]  kd_q;
  logic [LenW-1:0] e_abs_q;
  dmp_t            dmp1_q;

  always_ff @(posedge clk_i) begin
    kd_q    <= KdW'(stiff_i) * KdW'(d_abs);
    e_abs_q <= e_mag[LenW-1:0];
    dmp1_q  <= '{pa:     PdW'(damp_i) * PdW'(va_abs),
                 pb:     PdW'(damp_i) * PdW'(vb_abs),
                 neg_s:  tl.d[DiffW-1] == e_w[ErrW-1],
                 pos_va: !tl.va[CoordW-1],
                 pos_vb: !tl.vb[CoordW-1]};
  end

  // Split k*|d|*|e| into two partial products
  logic [PlW-1:0] pp_lo_q;
  logic [PhW-1:0] pp_hi_q;
  dmp_t           dmp2_q;

  always_ff @(posedge clk_i) begin
    pp_lo_q <= PlW'(kd_q[KdLoW-1:0]) * PlW'(e_abs_q);
    pp_hi_q <= PhW'(kd_q[KdW-1:KdLoW]) * PhW'(e_abs_q);
    dmp2_q  <= dmp1_q;
  end

  // Merge the partial products
  logic [SprW-1:0] mag_q;
  dmp_t            dmp3_q;

  always_ff @(posedge clk_i) begin
    mag_q  <= SprW'(pp_lo_q) + (SprW'(pp_hi_q) << KdLoW);
    dmp3_q <= dmp2_q;
  end

  // Sum spring and damping terms for both bodies
  logic [AccW-1:0] spr_a;
  logic [AccW-1:0] dmp_a;
  logic [AccW-1:0] dmp_b;
  logic [AccW-1:0] fa_q;
  logic [AccW-1:0] fb_q;

  always_comb begin
    spr_a = dmp3_q.neg_s ? -AccW'(mag_q) : AccW'(mag_q);
    dmp_a = AccW'({dmp3_q.pa, {DampShift{1'b0}}});
    dmp_b = AccW'({dmp3_q.pb, {DampShift{1'b0}}});
    if (dmp3_q.pos_va) begin
      dmp_a = -dmp_a;
    end
    if (dmp3_q.pos_vb) begin
      dmp_b = -dmp_b;
    end
  end

  always_ff @(posedge clk_i) begin
    fa_q <= spr_a + dmp_a;
    fb_q <= dmp_b - spr_a;
  end

  // Floor to Q16.16 and clamp to 32 bits
  logic fit_a;
  logic fit_b;
  sdf_lane_res_t res_q;

  always_comb begin
    fit_a = (&fa_q[AccW-1:FracDrop+CoordW-1]) | ~(|fa_q[AccW-1:FracDrop+CoordW-1]);
    fit_b = (&fb_q[AccW-1:FracDrop+CoordW-1]) | ~(|fb_q[AccW-1:FracDrop+CoordW-1]);
  end

  always_ff @(posedge clk_i) begin
    res_q.force_a <= fit_a ? fa_q[FracDrop+CoordW-1:FracDrop]
                           : {fa_q[AccW-1], {(CoordW-1){!fa_q[AccW-1]}}};
    res_q.force_b <= fit_b ? fb_q[FracDrop+CoordW-1:FracDrop]
                           : {fb_q[AccW-1], {(CoordW-1){!fb_q[AccW-1]}}};
    res_q.sat     <= !(fit_a && fit_b);
  end

  assign res_o = res_q;

endmodule

@@ rtl/spring_damper_force.sv @@
// Top level of the spring-damper force block: configuration registers,
// three axis lanes, length sum and square root, result merge.
// Depends on sdf_pkg, sdf_lane, sdf_sqrt and assert_macros.svh.
//
//  Channel  | Handshake            | Beat
//  ---------+----------------------+------------------------------------------
//  input    | start_i, busy_o      | pos_a/pos_b/vel_a/vel_b x,y,z
//  result   | done_o (one cycle)   | force_a/force_b x,y,z, zero_distance, saturated
//  config   | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// One beat is taken every cycle; busy_o stays low.
// A result strobes on done_o once its beat has passed the lane, the sum register,
// the 34-stage square root of |d|^2 and the merge register.
// Reset clears the configuration registers and the valid pipeline.
// The receiver cannot stall, so the pipeline never holds.
`include "assert_macros.svh"

module spring_damper_force (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  output logic                                done_o,
  input  logic                                cfg_we_i,
  input  logic [sdf_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [sdf_pkg::CoefW-1:0]           cfg_wdata_i,
  input  logic signed [sdf_pkg::CoordW-1:0]   pos_a_x_i,
  input  logic signed [sdf_pkg::CoordW-1:0]   pos_a_y_i,
  input  logic signed [sdf_pkg::CoordW-1:0]   pos_a_z_i,
  input  logic signed [sdf_pkg::CoordW-1:0]   pos_b_x_i,
  input  logic signed [sdf_pkg::CoordW-1:0]   pos_b_y_i,
  input  logic signed [sdf_pkg::CoordW-1:0]   pos_b_z_i,
  input  logic signed [sdf_pkg::CoordW-1:0]   vel_a_x_i,
  input  logic signed [sdf_pkg::CoordW-1:0]   vel_a_y_i,
  input  logic signed [sdf_pkg::CoordW-1:0]   vel_a_z_i,
  input  logic signed [sdf_pkg::CoordW-1:0]   vel_b_x_i,
  input  logic signed [sdf_pkg::CoordW-1:0]   vel_b_y_i,
  input  logic signed [sdf_pkg::CoordW-1:0]   vel_b_z_i,
  output logic signed [sdf_pkg::CoordW-1:0]   force_a_x_o,
  output logic signed [sdf_pkg::CoordW-1:0]   force_a_y_o,
  output logic signed [sdf_pkg::CoordW-1:0]   force_a_z_o,
  output logic signed [sdf_pkg::CoordW-1:0]   force_b_x_o,
  output logic signed [sdf_pkg::CoordW-1:0]   force_b_y_o,
  output logic signed [sdf_pkg::CoordW-1:0]   force_b_z_o,
  output logic                                zero_distance_o,
  output logic                                saturated_o
);
  import sdf_pkg::*;

  logic accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Configuration registers
  logic [NumAxes-1:0] en_q;
  logic [CoefW-1:0]   k_q [NumAxes];
  logic [CoefW-1:0]   c_q [NumAxes];
  logic [CoefW-1:0]   r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= '0;
      r_q  <= '0;
      for (int i = 0; i < NumAxes; i++) begin
        k_q[i] <= '0;
        c_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (sdf_reg_e'(cfg_idx_i))
        RegEnable:  en_q   <= cfg_wdata_i[NumAxes-1:0];
        RegStiffX:  k_q[0] <= cfg_wdata_i;
        RegStiffY:  k_q[1] <= cfg_wdata_i;
        RegStiffZ:  k_q[2] <= cfg_wdata_i;
        RegDampX:   c_q[0] <= cfg_wdata_i;
        RegDampY:   c_q[1] <= cfg_wdata_i;
        RegDampZ:   c_q[2] <= cfg_wdata_i;
        RegRestLen: r_q    <= cfg_wdata_i;
        default:    r_q    <= r_q;
      endcase
    end
  end

  // Gather the axis inputs for the lanes
  logic signed [CoordW-1:0] pa [NumAxes];
  logic signed [CoordW-1:0] pb [NumAxes];
  logic signed [CoordW-1:0] va [NumAxes];
  logic signed [CoordW-1:0] vb [NumAxes];

  assign pa = '{pos_a_x_i, pos_a_y_i, pos_a_z_i};
  assign pb = '{pos_b_x_i, pos_b_y_i, pos_b_z_i};
  assign va = '{vel_a_x_i, vel_a_y_i, vel_a_z_i};
  assign vb = '{vel_b_x_i, vel_b_y_i, vel_b_z_i};

  logic [SqW-1:0]  sq   [NumAxes];
  sdf_lane_res_t   lres [NumAxes];
  logic [LenW-1:0] len;

  for (genvar i = 0; i < NumAxes; i++) begin : g_lane
    sdf_lane u_lane (
      .clk_i   (clk_i),
      .pos_a_i (pa[i]),
      .pos_b_i (pb[i]),
      .vel_a_i (va[i]),
      .vel_b_i (vb[i]),
      .stiff_i (k_q[i]),
      .damp_i  (c_q[i]),
      .rest_i  (r_q),
      .len_i   (len),
      .sq_o    (sq[i]),
      .res_o   (lres[i])
    );
  end

  // Sum the squared differences
  logic [SumW-1:0] s_q;

  always_ff @(posedge clk_i) begin
    s_q <= SumW'(sq[0]) + SumW'(sq[1]) + SumW'(sq[2]);
  end

  sdf_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (s_q),
    .root_o (len)
  );

  // Advance the valid and coincidence flags alongside the beat
  logic [LatLane:1]    vld_q;
  logic [ZeroTaps-1:0] zdl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LatLane-1:1], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    zdl_q <= {zdl_q[ZeroTaps-2:0], s_q == '0};
  end

  // Merge the lanes: mask disabled axes and coincident bodies
  logic               z;
  logic [NumAxes-1:0] lane_sat;
  logic [CoordW-1:0]  fa_q [NumAxes];
  logic [CoordW-1:0]  fb_q [NumAxes];
  logic               done_q;
  logic               zero_q;
  logic               sat_q;

  always_comb begin
    z = zdl_q[ZeroTaps-1];
    for (int i = 0; i < NumAxes; i++) begin
      lane_sat[i] = lres[i].sat && en_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumAxes; i++) begin
      fa_q[i] <= (en_q[i] && !z) ? lres[i].force_a : '0;
      fb_q[i] <= (en_q[i] && !z) ? lres[i].force_b : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      zero_q <= 1'b0;
      sat_q  <= 1'b0;
    end else begin
      done_q <= vld_q[LatLane];
      zero_q <= vld_q[LatLane] && z;
      sat_q  <= vld_q[LatLane] && !z && (|lane_sat);
    end
  end

  assign done_o          = done_q;
  assign zero_distance_o = zero_q;
  assign saturated_o     = sat_q;
  assign force_a_x_o     = fa_q[0];
  assign force_a_y_o     = fa_q[1];
  assign force_a_z_o     = fa_q[2];
  assign force_b_x_o     = fb_q[0];
  assign force_b_y_o     = fb_q[1];
  assign force_b_z_o     = fb_q[2];

  // Checks
  `SDF_ASSERT_IMPL(a_flags_strobe, zero_distance_o || saturated_o, done_o, "flag without result strobe")
  `SDF_ASSERT_IMPL(a_zero_no_sat, zero_distance_o, !saturated_o, "saturated set with zero distance")
  `SDF_ASSERT_IMPL(a_zero_forces, zero_distance_o, force_a_x_o == '0 && force_a_y_o == '0 && force_a_z_o == '0 && force_b_x_o == '0 && force_b_y_o == '0 && force_b_z_o == '0, "nonzero force with zero distance")
  `SDF_ASSERT_NEXT(a_mask_x, !en_q[0], force_a_x_o == '0 && force_b_x_o == '0, "disabled x axis gave a force")

endmodule
